/* design/assert_macros.svh */
// assertion macros shared by the integrator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PMLI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmli check failed");

// next-cycle implication, disabled in reset
`define PMLI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmli check failed");

`endif

/* design/pmli_pkg.sv */
// shared types and constants of the point mass integrator
// no dependencies; used by every module of the block
package pmli_pkg;

    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // time step is unsigned q0.16, half kick uses dt/2
    localparam int DT_FRAC    = 16;
    localparam int HALF_SHIFT = DT_FRAC + 1;

    localparam int CMD_W       = 3;
    localparam int VEC_W       = 32;
    localparam int OUT_W       = 32;
    localparam int INV_MASS_W  = 32;
    localparam int TIME_STEP_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [INV_MASS_W-1:0]  INV_MASS_RESET  = 32'd65536;
    localparam logic [TIME_STEP_W-1:0] TIME_STEP_RESET = 16'd1092;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FORCE   = 3'd0,
        CMD_FULL_STEP   = 3'd1,
        CMD_FIRST_HALF  = 3'd2,
        CMD_SECOND_HALF = 3'd3,
        CMD_LOAD_POS    = 3'd4,
        CMD_LOAD_VEL    = 3'd5
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INV_MASS  = 2'd0,
        REG_TIME_STEP = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_ACC_A,
        ST_ACC_B,
        ST_HALF_A,
        ST_HALF_B,
        ST_KICK,
        ST_DRIFT_A,
        ST_DRIFT_B,
        ST_POS,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SRC_FORCE,
        SRC_ACC,
        SRC_VEL
    } mul_src_t;

    typedef enum logic [1:0] {
        SH_FRAC,
        SH_HALF,
        SH_DRIFT
    } shift_sel_t;

    typedef struct packed {
        logic       vec_load;
        logic       clr_sat;
        logic       mul_load;
        mul_src_t   mul_src;
        shift_sel_t mul_shift;
        logic       acc_wr;
        logic       force_clr;
        logic       half_wr;
        logic       kick_wr;
        logic       drift_wr;
        logic       pos_wr;
        logic       kick2_wr;
        logic       add_force;
        logic       load_pos;
        logic       load_vel;
    } lane_ctrl_t;

endpackage

/* design/pmli_mul.sv */
// two-stage multiply, floor shift and saturate unit of one lane
// depends on pmli_pkg
module pmli_mul #(
    parameter int FRAC_BITS   = pmli_pkg::DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = pmli_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                clk,
    input  logic                                load,
    input  pmli_pkg::shift_sel_t                shift_sel,
    input  logic signed [VALUE_WIDTH-1:0]       a,
    input  logic [pmli_pkg::INV_MASS_W-1:0]     b,
    output logic signed [VALUE_WIDTH-1:0]       res,
    output logic                                sat
);
    import pmli_pkg::*;

    localparam int VW   = VALUE_WIDTH;
    localparam int LO_W = VW / 2;
    localparam int HI_W = VW - LO_W;
    localparam int PW   = VW + INV_MASS_W + 1;
    localparam int LP_W = LO_W + INV_MASS_W;
    localparam int HP_W = HI_W + INV_MASS_W + 1;

    localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

    logic [LO_W+INV_MASS_W-1:0]        pp_lo_reg;
    logic [LO_W+INV_MASS_W-1:0]        pp_lo_next;
    logic signed [HI_W+INV_MASS_W:0]   pp_hi_reg;
    logic signed [HI_W+INV_MASS_W:0]   pp_hi_next;
    shift_sel_t                        sel_reg;
    logic signed [PW-1:0]              prod;
    logic signed [PW-1:0]              shifted;

    // split multiply: low half unsigned, high half signed
    always_comb
    begin
        pp_lo_next = LP_W'(a[LO_W-1:0]) * LP_W'(b);
        pp_hi_next = HP_W'($signed(a[VW-1:LO_W])) * HP_W'($signed({1'b0, b}));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            sel_reg   <= shift_sel;
        end
    end

    always_comb
    begin
        prod = $signed({pp_hi_reg, {LO_W{1'b0}}})
             + $signed({{(HI_W+1){1'b0}}, pp_lo_reg});
        unique case (sel_reg)
            SH_FRAC:  shifted = prod >>> FRAC_BITS;
            SH_HALF:  shifted = prod >>> HALF_SHIFT;
            SH_DRIFT: shifted = prod >>> DT_FRAC;
            default:  shifted = prod >>> DT_FRAC;
        endcase
        sat = !((&shifted[PW-1:VW-1]) || !(|shifted[PW-1:VW-1]));
        if (sat)
        begin
            res = shifted[PW-1] ? MINV : MAXV;
        end
        else
        begin
            res = shifted[VW-1:0];
        end
    end

endmodule

/* design/pmli_lane.sv */
// one axis of the integrator: state registers, adders and a multiply unit
// depends on pmli_pkg and pmli_mul
module pmli_lane #(
    parameter int FRAC_BITS   = pmli_pkg::DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = pmli_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmli_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [pmli_pkg::VEC_W-1:0]    vec,
    input  logic [pmli_pkg::INV_MASS_W-1:0]      inv_mass,
    input  logic [pmli_pkg::TIME_STEP_W-1:0]     time_step,
    output logic signed [VALUE_WIDTH-1:0]        pos,
    output logic signed [VALUE_WIDTH-1:0]        vel,
    output logic signed [VALUE_WIDTH-1:0]        acc,
    output logic                                 sat
);
    import pmli_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int PW = VW + INV_MASS_W + 1;

    localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

    logic signed [VW-1:0]    pos_reg, vel_reg, acc_reg, force_reg, half_reg, drift_reg;
    logic signed [VEC_W-1:0] vec_reg;
    logic                    sat_reg, sat_next;

    logic signed [VW-1:0]         mul_a;
    logic [INV_MASS_W-1:0]        mul_b;
    logic signed [VW-1:0]         mul_res;
    logic                         mul_sat;

    logic signed [PW-1:0] vec_ext, kick_sum, pos_sum, force_sum;
    logic signed [VW-1:0] vec_clamped;

    function automatic logic ovf_fn(input logic signed [PW-1:0] v);
        ovf_fn = !((&v[PW-1:VW-1]) || !(|v[PW-1:VW-1]));
    endfunction

    function automatic logic [VW-1:0] clamp_fn(input logic signed [PW-1:0] v);
        if (ovf_fn(v))
        begin
            clamp_fn = v[PW-1] ? MINV : MAXV;
        end
        else
        begin
            clamp_fn = v[VW-1:0];
        end
    endfunction

    always_comb
    begin
        unique case (ctrl.mul_src)
            SRC_FORCE:
            begin
                mul_a = force_reg;
                mul_b = inv_mass;
            end
            SRC_ACC:
            begin
                mul_a = acc_reg;
                mul_b = {{(INV_MASS_W-TIME_STEP_W){1'b0}}, time_step};
            end
            default:
            begin
                mul_a = vel_reg;
                mul_b = {{(INV_MASS_W-TIME_STEP_W){1'b0}}, time_step};
            end
        endcase
    end

    pmli_mul #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mul (
        .clk       (clk),
        .load      (ctrl.mul_load),
        .shift_sel (ctrl.mul_shift),
        .a         (mul_a),
        .b         (mul_b),
        .res       (mul_res),
        .sat       (mul_sat)
    );

    always_comb
    begin
        vec_ext     = PW'(vec_reg);
        vec_clamped = clamp_fn(vec_ext);
        kick_sum    = PW'(vel_reg) + PW'(half_reg);
        pos_sum     = PW'(pos_reg) + PW'(drift_reg);
        force_sum   = PW'(force_reg) + PW'(vec_clamped);

        sat_next = sat_reg;
        if (ctrl.clr_sat)
        begin
            sat_next = 1'b0;
        end
        if ((ctrl.acc_wr || ctrl.half_wr || ctrl.drift_wr) && mul_sat)
        begin
            sat_next = 1'b1;
        end
        if ((ctrl.kick_wr || ctrl.kick2_wr) && ovf_fn(kick_sum))
        begin
            sat_next = 1'b1;
        end
        if (ctrl.pos_wr && ovf_fn(pos_sum))
        begin
            sat_next = 1'b1;
        end
        if (ctrl.add_force && ovf_fn(force_sum))
        begin
            sat_next = 1'b1;
        end
        if ((ctrl.add_force || ctrl.load_pos || ctrl.load_vel) && ovf_fn(vec_ext))
        begin
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            acc_reg   <= '0;
            force_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            sat_reg <= sat_next;
            if (ctrl.acc_wr)
            begin
                acc_reg <= mul_res;
            end
            if (ctrl.force_clr)
            begin
                force_reg <= '0;
            end
            else if (ctrl.add_force)
            begin
                force_reg <= clamp_fn(force_sum);
            end
            if (ctrl.kick_wr || ctrl.kick2_wr)
            begin
                vel_reg <= clamp_fn(kick_sum);
            end
            else if (ctrl.load_vel)
            begin
                vel_reg <= vec_clamped;
            end
            if (ctrl.pos_wr)
            begin
                pos_reg <= clamp_fn(pos_sum);
            end
            else if (ctrl.load_pos)
            begin
                pos_reg <= vec_clamped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.vec_load)
        begin
            vec_reg <= vec;
        end
        if (ctrl.half_wr)
        begin
            half_reg <= mul_res;
        end
        if (ctrl.drift_wr)
        begin
            drift_reg <= mul_res;
        end
    end

    assign pos = pos_reg;
    assign vel = vel_reg;
    assign acc = acc_reg;
    assign sat = sat_reg;

endmodule

/* design/pmli_ctrl.sv */
// sequencer of the integrator: decodes the command and steps all lanes
// depends on pmli_pkg
module pmli_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [pmli_pkg::CMD_W-1:0]   cmd,
    input  logic                         out_free,
    output logic                         in_ready,
    output logic                         done,
    output pmli_pkg::lane_ctrl_t         ctrl
);
    import pmli_pkg::*;

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.vec_load = 1'b1;
                    ctrl.clr_sat  = 1'b1;
                    cmd_next      = cmd;
                    if ((cmd == CMD_FULL_STEP) || (cmd == CMD_FIRST_HALF)
                        || (cmd == CMD_SECOND_HALF))
                    begin
                        state_next = ST_ACC_A;
                    end
                    else
                    begin
                        state_next = ST_SIMPLE;
                    end
                end
            end
            ST_SIMPLE:
            begin
                ctrl.add_force = (cmd_reg == CMD_ADD_FORCE);
                ctrl.load_pos  = (cmd_reg == CMD_LOAD_POS);
                ctrl.load_vel  = (cmd_reg == CMD_LOAD_VEL);
                state_next     = ST_DONE;
            end
            ST_ACC_A:
            begin
                ctrl.mul_load  = 1'b1;
                ctrl.mul_src   = SRC_FORCE;
                ctrl.mul_shift = SH_FRAC;
                state_next     = ST_ACC_B;
            end
            ST_ACC_B:
            begin
                ctrl.acc_wr    = 1'b1;
                ctrl.force_clr = 1'b1;
                state_next     = ST_HALF_A;
            end
            ST_HALF_A:
            begin
                ctrl.mul_load  = 1'b1;
                ctrl.mul_src   = SRC_ACC;
                ctrl.mul_shift = SH_HALF;
                state_next     = ST_HALF_B;
            end
            ST_HALF_B:
            begin
                ctrl.half_wr = 1'b1;
                state_next   = ST_KICK;
            end
            ST_KICK:
            begin
                ctrl.kick_wr = 1'b1;
                if (cmd_reg == CMD_SECOND_HALF)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DRIFT_A;
                end
            end
            ST_DRIFT_A:
            begin
                ctrl.mul_load  = 1'b1;
                ctrl.mul_src   = SRC_VEL;
                ctrl.mul_shift = SH_DRIFT;
                state_next     = ST_DRIFT_B;
            end
            ST_DRIFT_B:
            begin
                ctrl.drift_wr = 1'b1;
                state_next    = ST_POS;
            end
            ST_POS:
            begin
                ctrl.pos_wr   = 1'b1;
                ctrl.kick2_wr = (cmd_reg == CMD_FULL_STEP);
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/point_mass_leapfrog_integrator.sv */
// top level of the kick-drift-kick point mass integrator
// depends on pmli_pkg, pmli_ctrl, pmli_lane (with pmli_mul) and assert_macros.svh
//
//   channel   handshake             payload
//   in        in_valid / in_ready   cmd, vec_x, vec_y, vec_z
//   out       out_valid / out_ready pos_*, vel_*, acc_*, saturated
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item at a time through a shared sequencer; three axis lanes run in lockstep
// steps: acceleration, half kick, kick; full or first half then drift and position
// (full adds the second kick); up to three dependent two-stage multiplies per lane
// reset clears position, velocity, acceleration and force sum and loads default config
// a result waiting in the output register does not block the next transfer in;
// the sequencer holds in its done state only if a second result would overwrite it
`include "assert_macros.svh"

module point_mass_leapfrog_integrator #(
    parameter int FRAC_BITS   = pmli_pkg::DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = pmli_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [pmli_pkg::CMD_W-1:0]             cmd,
    input  logic signed [pmli_pkg::VEC_W-1:0]      vec_x,
    input  logic signed [pmli_pkg::VEC_W-1:0]      vec_y,
    input  logic signed [pmli_pkg::VEC_W-1:0]      vec_z,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pmli_pkg::OUT_W-1:0]      pos_x,
    output logic signed [pmli_pkg::OUT_W-1:0]      pos_y,
    output logic signed [pmli_pkg::OUT_W-1:0]      pos_z,
    output logic signed [pmli_pkg::OUT_W-1:0]      vel_x,
    output logic signed [pmli_pkg::OUT_W-1:0]      vel_y,
    output logic signed [pmli_pkg::OUT_W-1:0]      vel_z,
    output logic signed [pmli_pkg::OUT_W-1:0]      acc_x,
    output logic signed [pmli_pkg::OUT_W-1:0]      acc_y,
    output logic signed [pmli_pkg::OUT_W-1:0]      acc_z,
    output logic                                   saturated,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pmli_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [pmli_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import pmli_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int NAXES  = 3;
    // width that holds both a state value and the 32-bit result field
    localparam int OW     = (VW > OUT_W) ? VW : OUT_W;

    // configuration registers
    logic [INV_MASS_W-1:0]  inv_mass_reg;
    logic [TIME_STEP_W-1:0] time_step_reg;

    // time step write seen by the checks
    logic                   ts_write;
    logic [TIME_STEP_W-1:0] ts_data;

    // sequencer to lanes
    lane_ctrl_t ctrl;
    logic       item_done;
    logic       out_free;

    // per-axis lane signals
    logic signed [VEC_W-1:0] vec_w [NAXES];
    logic signed [VW-1:0]    pos_w [NAXES];
    logic signed [VW-1:0]    vel_w [NAXES];
    logic signed [VW-1:0]    acc_w [NAXES];
    logic [NAXES-1:0]        sat_w;

    // output register (merging stage)
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  pos_out_reg [NAXES];
    logic signed [OUT_W-1:0]  vel_out_reg [NAXES];
    logic signed [OUT_W-1:0]  acc_out_reg [NAXES];
    logic                     sat_out_reg;

    // state values leave as their low 32 bits after sign extension
    function automatic logic [OUT_W-1:0] to_out(input logic signed [VW-1:0] v);
        logic signed [OW-1:0] w;
        w      = OW'(v);
        to_out = w[OUT_W-1:0];
    endfunction

    // config writes go straight into the registers, always ready
    assign cfg_ready = 1'b1;

    assign ts_write = cfg_valid && cfg_ready && (cfg_index == REG_TIME_STEP);
    assign ts_data  = cfg_data[TIME_STEP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg  <= INV_MASS_RESET;
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INV_MASS:  inv_mass_reg  <= cfg_data[INV_MASS_W-1:0];
                REG_TIME_STEP: time_step_reg <= cfg_data[TIME_STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    // output slot is free when empty or drained by a transfer this cycle
    assign out_free = !out_valid_reg || out_ready;

    pmli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .out_free (out_free),
        .in_ready (in_ready),
        .done     (item_done),
        .ctrl     (ctrl)
    );

    assign vec_w[0] = vec_x;
    assign vec_w[1] = vec_y;
    assign vec_w[2] = vec_z;

    // one lane per axis, all driven by the same control word
    for (genvar g = 0; g < NAXES; g++)
    begin : g_lane
        pmli_lane #(
            .FRAC_BITS   (FRAC_BITS),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .vec       (vec_w[g]),
            .inv_mass  (inv_mass_reg),
            .time_step (time_step_reg),
            .pos       (pos_w[g]),
            .vel       (vel_w[g]),
            .acc       (acc_w[g]),
            .sat       (sat_w[g])
        );
    end

    // merging stage: snapshot of all lanes plus the combined clamp flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (item_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_done)
        begin
            for (int i = 0; i < NAXES; i++)
            begin
                pos_out_reg[i] <= to_out(pos_w[i]);
                vel_out_reg[i] <= to_out(vel_w[i]);
                acc_out_reg[i] <= to_out(acc_w[i]);
            end
            sat_out_reg <= |sat_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_out_reg[0];
    assign pos_y     = pos_out_reg[1];
    assign pos_z     = pos_out_reg[2];
    assign vel_x     = vel_out_reg[0];
    assign vel_y     = vel_out_reg[1];
    assign vel_z     = vel_out_reg[2];
    assign acc_x     = acc_out_reg[0];
    assign acc_y     = acc_out_reg[1];
    assign acc_z     = acc_out_reg[2];
    assign saturated = sat_out_reg;

    // one item in flight: no second transfer in right behind the first
    `PMLI_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    // a result only appears after the sequencer finished an item
    `PMLI_ASSERT_IMP(a_result_after_done, clk, rst_n, $rose(out_valid_reg), $past(item_done))
    // a time step write is visible on the next cycle
    `PMLI_ASSERT_NEXT(a_time_step_write, clk, rst_n, ts_write, time_step_reg == $past(ts_data))

endmodule

/* verif/point_mass_leapfrog_integrator_test.sv */
// self-checking testbench for point_mass_leapfrog_integrator
// depends on pmli_pkg and the integrator rtl; holds its own fixed-point model of the mass
module point_mass_leapfrog_integrator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pmli_pkg::*;

    // codes the block leaves unused, they must change nothing
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [64:0] WORD_MAX = 65'sd2147483647;
    localparam logic signed [64:0] WORD_MIN = -65'sd2147483648;

    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;

    // whole state of the mass as the block reports it after one command
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] acc;
        logic             sat;
    } mass_state_t;

    // fixed-point model of the mass plus the queue of reports still owed by the block
    class integrator_scoreboard;
        logic signed [31:0] position [3];
        logic signed [31:0] velocity [3];
        logic signed [31:0] acceleration [3];
        logic signed [31:0] force_sum [3];
        logic [INV_MASS_W-1:0]  inv_mass;
        logic [TIME_STEP_W-1:0] dt;
        mass_state_t owed_q [$];
        int unsigned fails;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                position[i]     = '0;
                velocity[i]     = '0;
                acceleration[i] = '0;
                force_sum[i]    = '0;
            end
            inv_mass = INV_MASS_RESET;
            dt       = TIME_STEP_RESET;
            fails    = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INV_MASS:  inv_mass = data[INV_MASS_W-1:0];
                REG_TIME_STEP: dt = data[TIME_STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp_word(logic signed [64:0] v, inout bit clamped);
            if (v > WORD_MAX)
            begin
                clamped = 1'b1;
                return WORD_MAX[31:0];
            end
            if (v < WORD_MIN)
            begin
                clamped = 1'b1;
                return WORD_MIN[31:0];
            end
            return v[31:0];
        endfunction

        // signed times unsigned, floor-shifted, then clamped
        function logic signed [31:0] scale_trunc(logic signed [31:0] a, logic [31:0] b,
                                                 int unsigned sh, inout bit clamped);
            logic signed [64:0] prod;
            prod = $signed({{33{a[31]}}, a}) * $signed({33'd0, b});
            return clamp_word(prod >>> sh, clamped);
        endfunction

        function logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [31:0] b,
                                             inout bit clamped);
            return clamp_word(65'(a) + 65'(b), clamped);
        endfunction

        function void integrate(bit with_drift, bit with_second_kick, inout bit clamped);
            logic signed [31:0] half;
            logic signed [31:0] drift;
            for (int i = 0; i < 3; i++)
            begin
                acceleration[i] = scale_trunc(force_sum[i], inv_mass, DEF_FRAC_BITS, clamped);
                half = scale_trunc(acceleration[i], {16'd0, dt}, HALF_SHIFT, clamped);
                velocity[i] = add_sat(velocity[i], half, clamped);
                if (with_drift)
                begin
                    drift = scale_trunc(velocity[i], {16'd0, dt}, DT_FRAC, clamped);
                    position[i] = add_sat(position[i], drift, clamped);
                end
                if (with_second_kick)
                    velocity[i] = add_sat(velocity[i], half, clamped);
                force_sum[i] = '0;
            end
        endfunction

        function void note_input(logic [CMD_W-1:0] code, logic signed [31:0] x,
                                 logic signed [31:0] y, logic signed [31:0] z);
            logic signed [31:0] v [3];
            bit clamped;
            mass_state_t r;
            v = '{x, y, z};
            clamped = 1'b0;
            case (code)
                CMD_ADD_FORCE:
                    for (int i = 0; i < 3; i++)
                        force_sum[i] = add_sat(force_sum[i], v[i], clamped);
                CMD_FULL_STEP:   integrate(1'b1, 1'b1, clamped);
                CMD_FIRST_HALF:  integrate(1'b1, 1'b0, clamped);
                CMD_SECOND_HALF: integrate(1'b0, 1'b0, clamped);
                CMD_LOAD_POS:    position = v;
                CMD_LOAD_VEL:    velocity = v;
                default: ;
            endcase
            for (int i = 0; i < 3; i++)
            begin
                r.pos[i] = position[i];
                r.vel[i] = velocity[i];
                r.acc[i] = acceleration[i];
            end
            r.sat = clamped;
            owed_q.push_back(r);
        endfunction

        function void compare_word(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
                fails++;
            end
        endfunction

        function void check_result(mass_state_t got);
            string axis [3] = '{"x", "y", "z"};
            mass_state_t want;
            if (owed_q.size() == 0)
            begin
                $error("state report with no command waiting for it");
                fails++;
                return;
            end
            want = owed_q.pop_front();
            for (int i = 0; i < 3; i++)
            begin
                compare_word({"pos_", axis[i]}, want.pos[i], got.pos[i]);
                compare_word({"vel_", axis[i]}, want.vel[i], got.vel[i]);
                compare_word({"acc_", axis[i]}, want.acc[i], got.acc[i]);
            end
            compare_word("saturated", {31'd0, want.sat}, {31'd0, got.sat});
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                           in_valid;
    logic                           in_ready;
    logic [CMD_W-1:0]               cmd;
    logic signed [VEC_W-1:0]        vec_x;
    logic signed [VEC_W-1:0]        vec_y;
    logic signed [VEC_W-1:0]        vec_z;

    logic                           out_valid;
    logic                           out_ready;
    logic signed [OUT_W-1:0]        pos_x;
    logic signed [OUT_W-1:0]        pos_y;
    logic signed [OUT_W-1:0]        pos_z;
    logic signed [OUT_W-1:0]        vel_x;
    logic signed [OUT_W-1:0]        vel_y;
    logic signed [OUT_W-1:0]        vel_z;
    logic signed [OUT_W-1:0]        acc_x;
    logic signed [OUT_W-1:0]        acc_y;
    logic signed [OUT_W-1:0]        acc_z;
    logic                           saturated;

    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_INDEX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;

    integrator_scoreboard mass_model = new();

    // idling odds in percent, changed per phase
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned items_sent      = 0;
    int unsigned quiet_cycles    = 0;

    point_mass_leapfrog_integrator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .acc_z     (acc_z),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // all transfers are observed at the rising edge, inputs only ever move at the falling one;
    // commands are logged before results so the model is never behind the block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mass_model.write_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                mass_model.note_input(cmd, vec_x, vec_y, vec_z);
            if (out_valid && out_ready)
                mass_model.check_result({{pos_z, pos_y, pos_x}, {vel_z, vel_y, vel_x},
                                         {acc_z, acc_y, acc_x}, saturated});
        end
    end

    // watchdog: a long run of cycles with no transfer on any channel means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("point_mass_leapfrog_integrator: mismatch");
                $finish;
            end
        end
    end

    // receiver side: back-pressure drawn fresh every cycle
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // mode 0 no idling, 1 sender idles, 2 receiver stalls, 3 both lightly
    task automatic set_idling(int mode);
        case (mode)
            1:       begin sender_idle_pct = 51; recv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  recv_stall_pct = 51; end
            3:       begin sender_idle_pct = 15; recv_stall_pct = 15; end
            default: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // one command transfer; entered and left at a falling edge, valid stays up on return
    task automatic send_item(logic [CMD_W-1:0] code, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd      = code;
        vec_x    = x;
        vec_y    = y;
        vec_z    = z;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        if (code <= CMD_LOAD_VEL)
            items_sent++;
    endtask

    // register writes only happen with nothing in flight
    task automatic wait_drained();
        in_valid = 1'b0;
        while (mass_model.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // realistic magnitudes and full-range words in equal share, plus some corner words
    function automatic logic [31:0] pick_component();
        logic [31:0] corners [5] = '{VAL_MAX, VAL_MIN, 32'd0, 32'd1, 32'hFFFF_FFFF};
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return $urandom();
        if (sel < 8)
            return 32'($urandom_range(2 * 1048576)) - 32'd1048576;
        return corners[$urandom_range(4)];
    endfunction

    task automatic send_random(logic [CMD_W-1:0] code);
        send_item(code, pick_component(), pick_component(), pick_component());
    endtask

    // one burst of traffic shaped like real use: forces collected, then a step
    task automatic run_frame();
        int unsigned r;
        int unsigned n_forces;
        logic [CMD_W-1:0] steps [3] = '{CMD_FULL_STEP, CMD_FULL_STEP, CMD_FIRST_HALF};
        r = $urandom_range(99);
        n_forces = $urandom_range(3);
        if (r < 65)
        begin
            repeat (n_forces)
                send_random(CMD_ADD_FORCE);
            if ($urandom_range(3) == 0)
                send_random(CMD_SECOND_HALF);
            else
                send_random(steps[$urandom_range(2)]);
        end
        else if (r < 75)
        begin
            // leapfrog split: first half, forces at the new position, second half
            send_random(CMD_FIRST_HALF);
            repeat (n_forces)
                send_random(CMD_ADD_FORCE);
            send_random(CMD_SECOND_HALF);
        end
        else if (r < 87)
            send_random($urandom_range(1) ? CMD_LOAD_POS : CMD_LOAD_VEL);
        else
            send_random(3'($urandom_range(7)));
    endtask

    initial
    begin
        logic [INV_MASS_W-1:0]  phase_inv_mass [NUM_PHASES] = '{
            32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0000_8000, 32'd0, 32'd65536, 32'd0
        };
        logic [TIME_STEP_W-1:0] phase_dt [NUM_PHASES] = '{
            16'd1092, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'd0, 16'd0, 16'd0
        };
        logic [INV_MASS_W-1:0]  inv;
        logic [TIME_STEP_W-1:0] step_dt;
        int unsigned target;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_ADD_FORCE;
        vec_x     = '0;
        vec_y     = '0;
        vec_z     = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_INV_MASS;
        cfg_data  = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset config (inverse mass 1.0, dt about 1/60)
        set_idling(0);
        send_item(CMD_LOAD_POS, VAL_MAX, VAL_MIN, 32'd0);
        send_item(CMD_LOAD_VEL, VAL_MIN, VAL_MAX, 32'hFFFF_FFFF);
        // force sum driven into both rails
        send_item(CMD_ADD_FORCE, VAL_MAX, VAL_MIN, 32'd1);
        send_item(CMD_ADD_FORCE, VAL_MAX, VAL_MIN, 32'hFFFF_FFFF);
        // step payload must be ignored
        send_item(CMD_FULL_STEP, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
        send_item(CMD_ADD_FORCE, ONE_Q16, -ONE_Q16, 32'h0000_8000);
        send_item(CMD_FIRST_HALF, 32'd0, 32'd0, 32'd0);
        send_item(CMD_ADD_FORCE, 32'hFFFF_FFFF, 32'd1, -ONE_Q16);
        send_item(CMD_SECOND_HALF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // unused codes leave everything alone and never flag saturation
        send_item(CMD_SPARE_A, VAL_MAX, VAL_MIN, 32'hFFFF_FFFF);
        send_item(CMD_SPARE_B, VAL_MIN, VAL_MAX, ONE_Q16);
        // step with an empty force sum zeroes the acceleration
        send_item(CMD_SECOND_HALF, 32'd0, 32'd0, 32'd0);
        send_item(CMD_LOAD_POS, 32'd0, 32'd0, 32'd0);
        send_item(CMD_LOAD_VEL, ONE_Q16, -ONE_Q16, 32'd0);
        send_item(CMD_FULL_STEP, 32'd0, 32'd0, 32'd0);
        send_item(CMD_FIRST_HALF, 32'd0, 32'd0, 32'd0);
        send_item(CMD_ADD_FORCE, VAL_MIN, VAL_MIN, VAL_MIN);
        send_item(CMD_ADD_FORCE, VAL_MIN, VAL_MIN, VAL_MIN);
        send_item(CMD_FULL_STEP, 32'd0, 32'd0, 32'd0);

        // random phases, each with its own config and idling pattern;
        // phases 5 and 7 draw random register values
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            inv     = phase_inv_mass[p];
            step_dt = phase_dt[p];
            if (p == 5 || p == 7)
            begin
                inv     = $urandom();
                step_dt = 16'($urandom_range(65535));
            end
            write_reg(REG_INV_MASS, inv);
            // upper data bits of the time step are junk and must be dropped
            write_reg(REG_TIME_STEP, {16'($urandom()), step_dt});
            set_idling(p % 4);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                run_frame();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mass_model.fails == 0 && mass_model.pending() == 0)
            $display("point_mass_leapfrog_integrator: match");
        else
            $display("point_mass_leapfrog_integrator: mismatch");
        $finish;
    end

endmodule
